// ===== design/i2cm_pkg.sv =====
`timescale 1ns / 1ps

package i2cm_pkg;

   typedef enum logic [3:0] {
      ST_IDLE = 4'd0,
      ST_ST_A = 4'd1,
      ST_ST_B = 4'd2,
      ST_ST_C = 4'd3,
      ST_SP_A = 4'd4,
      ST_SP_B = 4'd5,
      ST_SP_C = 4'd6,
      ST_WR_D = 4'd7,
      ST_WR_H = 4'd8,
      ST_WR_L = 4'd9,
      ST_AK_R = 4'd10,
      ST_AK_H = 4'd11,
      ST_AK_P = 4'd12,
      ST_RD_L = 4'd13,
      ST_RD_H = 4'd14
   } cmd_state_type;

   localparam logic [2:0] OP_NONE  = 3'd0;
   localparam logic [2:0] OP_START = 3'd1;
   localparam logic [2:0] OP_WRITE = 3'd2;
   localparam logic [2:0] OP_READ  = 3'd3;
   localparam logic [2:0] OP_STOP  = 3'd4;

   localparam logic CSR_PHASE_TICKS = 1'b0;
   localparam logic CSR_ACK_TIMEOUT = 1'b1;

   localparam logic [15:0] PHASE_TICKS_RESET = 16'd42;
   localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd50;
   localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;
   localparam logic [7:0]  WAIT_MAX          = 8'hFF;

   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] write_data;
      logic       send_ack;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       ack_ok;
      logic       timed_out;
   } rsp_type;

endpackage

// ===== design/i2cm_core.sv =====
`timescale 1ns / 1ps

module i2cm_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  i2cm_pkg::req_type req,
   input  logic [15:0]       phase_ticks,
   input  logic [7:0]        ack_timeout,
   output i2cm_pkg::rsp_type rsp
);

   i2cm_pkg::cmd_state_type st_ff, st_in;
   logic [15:0] pc_ff, pc_in;
   logic [3:0]  bc_ff, bc_in;
   logic [7:0]  sr_ff, sr_in;
   logic [7:0]  wc_ff, wc_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   logic        ack_ff, ack_in;
   logic        tmo_ff, tmo_in;
   logic        sack_ff, sack_in;
   logic [7:0]  rd_ff, rd_in;

   logic [15:0] pt;
   logic [15:0] pcd;
   logic [3:0]  bc1;
   logic [7:0]  wc1;
   logic        done;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= i2cm_pkg::ST_IDLE;
         pc_ff   <= '0;
         bc_ff   <= '0;
         sr_ff   <= '0;
         wc_ff   <= '0;
         scl_ff  <= 1'b1;
         sda_ff  <= 1'b1;
         ack_ff  <= 1'b0;
         tmo_ff  <= 1'b0;
         sack_ff <= 1'b0;
         rd_ff   <= '0;
      end else if (step_en) begin
         st_ff   <= st_in;
         pc_ff   <= pc_in;
         bc_ff   <= bc_in;
         sr_ff   <= sr_in;
         wc_ff   <= wc_in;
         scl_ff  <= scl_in;
         sda_ff  <= sda_in;
         ack_ff  <= ack_in;
         tmo_ff  <= tmo_in;
         sack_ff <= sack_in;
         rd_ff   <= rd_in;
      end
   end

   always_comb begin
      st_in   = st_ff;
      pc_in   = pc_ff;
      bc_in   = bc_ff;
      sr_in   = sr_ff;
      wc_in   = wc_ff;
      scl_in  = scl_ff;
      sda_in  = sda_ff;
      ack_in  = ack_ff;
      tmo_in  = tmo_ff;
      sack_in = sack_ff;
      rd_in   = rd_ff;
      done    = 1'b0;
      pt      = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
      pcd     = (pc_ff != 16'd0) ? pc_ff - 16'd1 : 16'd0;
      bc1     = bc_ff + 4'd1;
      wc1     = (wc_ff == i2cm_pkg::WAIT_MAX) ? wc_ff : wc_ff + 8'd1;
      if (st_ff == i2cm_pkg::ST_IDLE) begin
         unique case (req.operation)
            i2cm_pkg::OP_START: begin
               sda_in = 1'b1;
               scl_in = 1'b1;
               st_in  = i2cm_pkg::ST_ST_A;
               pc_in  = pt;
            end
            i2cm_pkg::OP_WRITE: begin
               ack_in = 1'b0;
               tmo_in = 1'b0;
               bc_in  = '0;
               scl_in = 1'b0;
               sda_in = req.write_data[7];
               sr_in  = {req.write_data[6:0], 1'b0};
               st_in  = i2cm_pkg::ST_WR_D;
               pc_in  = pt;
            end
            i2cm_pkg::OP_READ: begin
               sack_in = req.send_ack;
               sr_in   = '0;
               bc_in   = '0;
               sda_in  = 1'b1;
               scl_in  = 1'b0;
               st_in   = i2cm_pkg::ST_RD_L;
               pc_in   = pt;
            end
            i2cm_pkg::OP_STOP: begin
               scl_in = 1'b0;
               sda_in = 1'b0;
               st_in  = i2cm_pkg::ST_SP_A;
               pc_in  = pt;
            end
            default: begin
            end
         endcase
      end else begin
         pc_in = pcd;
         if (pcd == 16'd0) begin
            unique case (st_ff)
               i2cm_pkg::ST_ST_A: begin
                  sda_in = 1'b0;
                  st_in  = i2cm_pkg::ST_ST_B;
                  pc_in  = pt;
               end
               i2cm_pkg::ST_ST_B: begin
                  scl_in = 1'b0;
                  st_in  = i2cm_pkg::ST_ST_C;
                  pc_in  = pt;
               end
               i2cm_pkg::ST_SP_A: begin
                  scl_in = 1'b1;
                  st_in  = i2cm_pkg::ST_SP_B;
                  pc_in  = pt;
               end
               i2cm_pkg::ST_SP_B: begin
                  sda_in = 1'b1;
                  st_in  = i2cm_pkg::ST_SP_C;
                  pc_in  = pt;
               end
               i2cm_pkg::ST_WR_D: begin
                  scl_in = 1'b1;
                  st_in  = i2cm_pkg::ST_WR_H;
                  pc_in  = pt;
               end
               i2cm_pkg::ST_WR_H: begin
                  scl_in = 1'b0;
                  st_in  = i2cm_pkg::ST_WR_L;
                  pc_in  = pt;
               end
               i2cm_pkg::ST_WR_L: begin
                  bc_in = bc1;
                  pc_in = pt;
                  if (bc1 < i2cm_pkg::BITS_PER_BYTE) begin
                     sda_in = sr_ff[7];
                     sr_in  = {sr_ff[6:0], 1'b0};
                     st_in  = i2cm_pkg::ST_WR_D;
                  end else begin
                     sda_in = 1'b1;
                     wc_in  = '0;
                     st_in  = i2cm_pkg::ST_AK_R;
                  end
               end
               i2cm_pkg::ST_AK_R: begin
                  scl_in = 1'b1;
                  st_in  = i2cm_pkg::ST_AK_H;
                  pc_in  = pt;
               end
               i2cm_pkg::ST_AK_H, i2cm_pkg::ST_AK_P: begin
                  if (!req.sda_in) begin
                     scl_in = 1'b0;
                     ack_in = 1'b1;
                     st_in  = i2cm_pkg::ST_IDLE;
                     pc_in  = '0;
                     done   = 1'b1;
                  end else begin
                     wc_in = wc1;
                     pc_in = pt;
                     if (wc1 > ack_timeout) begin
                        tmo_in = 1'b1;
                        scl_in = 1'b0;
                        sda_in = 1'b0;
                        st_in  = i2cm_pkg::ST_SP_A;
                     end else begin
                        st_in = i2cm_pkg::ST_AK_P;
                     end
                  end
               end
               i2cm_pkg::ST_RD_L: begin
                  scl_in = 1'b1;
                  if (bc_ff < i2cm_pkg::BITS_PER_BYTE) begin
                     sr_in = {sr_ff[6:0], req.sda_in};
                  end
                  st_in = i2cm_pkg::ST_RD_H;
                  pc_in = pt;
               end
               i2cm_pkg::ST_RD_H: begin
                  scl_in = 1'b0;
                  if (bc_ff < i2cm_pkg::BITS_PER_BYTE) begin
                     bc_in = bc1;
                     if (bc1 == i2cm_pkg::BITS_PER_BYTE) begin
                        sda_in = ~sack_ff;
                     end
                     st_in = i2cm_pkg::ST_RD_L;
                     pc_in = pt;
                  end else begin
                     rd_in = sr_ff;
                     st_in = i2cm_pkg::ST_IDLE;
                     pc_in = '0;
                     done  = 1'b1;
                  end
               end
               default: begin
                  st_in = i2cm_pkg::ST_IDLE;
                  pc_in = '0;
                  done  = 1'b1;
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp.scl_out   = scl_in;
      rsp.sda_out   = sda_in;
      rsp.busy_res  = (st_in != i2cm_pkg::ST_IDLE);
      rsp.done_res  = done;
      rsp.read_data = rd_in;
      rsp.ack_ok    = ack_in;
      rsp.timed_out = tmo_in;
   end

endmodule

// ===== design/i2c_master_byte_engine_top.sv =====
`timescale 1ns / 1ps

// Tick-driven I2C master byte engine. Every req transfer is one tick carrying a
// command (tuser) and the sampled SDA level; every tick yields exactly one rsp
// transfer with the SCL/SDA drives and status after that tick. Commands are
// taken only while idle; others are ignored. Each pin phase lasts phase_ticks
// ticks (0 acts as 1). One tick is processed per clock while rsp is not stalled: a
// tick is held in an input register and evaluated in one pass into the output
// register, so with rsp_tready high a tick is accepted every cycle and its result
// is offered on rsp from the output register. Configuration must be written
// through csr_* only while idle; the block itself does not enforce this.
module i2c_master_byte_engine_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // write_data[7:0], send_ack[8], sda_in[9], zero
   input  logic [2:0]  req_tuser,   // operation[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // scl_out[0], sda_out[1], busy_res[2], done_res[3], read_data[11:4],
   // ack_ok[12], timed_out[13], zero
   output logic [15:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   logic                  in_valid_ff;
   i2cm_pkg::req_type     in_ff;
   logic                  out_valid_ff;
   i2cm_pkg::rsp_type     out_ff;
   i2cm_pkg::rsp_type     step_rsp;
   logic [15:0]           phase_ticks_ff;
   logic [7:0]            ack_timeout_ff;
   logic                  out_room;
   logic                  step_en;

   assign out_room   = !out_valid_ff || rsp_tready;
   assign step_en    = in_valid_ff && out_room;
   assign req_tready = !in_valid_ff || out_room;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= i2cm_pkg::PHASE_TICKS_RESET;
         ack_timeout_ff <= i2cm_pkg::ACK_TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == i2cm_pkg::CSR_PHASE_TICKS) begin
            phase_ticks_ff <= csr_wdata;
         end else begin
            ack_timeout_ff <= csr_wdata[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_ff.operation  <= req_tuser;
         in_ff.write_data <= req_tdata[7:0];
         in_ff.send_ack   <= req_tdata[8];
         in_ff.sda_in     <= req_tdata[9];
      end
   end

   i2cm_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step_en     (step_en),
      .req         (in_ff),
      .phase_ticks (phase_ticks_ff),
      .ack_timeout (ack_timeout_ff),
      .rsp         (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_room) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         out_ff <= step_rsp;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_ff.timed_out, out_ff.ack_ok, out_ff.read_data,
                        out_ff.done_res, out_ff.busy_res, out_ff.sda_out, out_ff.scl_out};

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.done_res) |-> !out_ff.busy_res)
      else $error("done reported while still busy");

   a_ack_tmo_excl: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_ff.ack_ok && out_ff.timed_out))
      else $error("ack and timeout flagged together");

   a_step_moves_out: assert property (@(posedge clock) disable iff (reset)
      step_en |=> out_valid_ff)
      else $error("evaluated tick lost before output register");

endmodule
